@@ rtl/rrqs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants of the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

   // field widths fixed by the command and result formats
   localparam int CMD_W      = 2;
   localparam int TASK_W     = 4;
   localparam int QNT_W      = 16;
   localparam int CNT_OUT_W  = 5;

   // task_req can only name this many tasks
   localparam int TASK_ADDR_MAX = 2 ** TASK_W;

   localparam int               TASK_COUNT_DEF = 16;
   localparam logic [QNT_W-1:0] QUANTUM_RESET  = 16'd20;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK        = 2'd0,
      CMD_MAKE_READY  = 2'd1,
      CMD_BLOCK       = 2'd2,
      CMD_SET_QUANTUM = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      TS_BLOCKED = 2'd0,
      TS_READY   = 2'd1,
      TS_RUNNING = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type            command;
      logic [TASK_W-1:0]  task_req;
      logic [QNT_W-1:0]   quantum_value;
   } req_item_type;

   typedef struct packed {
      logic [TASK_W-1:0]    running_task;
      logic                 switched;
      logic                 refused;
      logic [QNT_W-1:0]     remaining;
      logic [CNT_OUT_W-1:0] ready_count;
   } rsp_item_type;

endpackage

@@ rtl/rrqs_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqs_core
// Scheduler state (task status, quantum table, ready FIFO, running task and
// tick counter) and the single-pass update for one command.
// ----------------------------------------------------------------------------
module rrqs_core #(
   parameter int TASK_COUNT = rrqs_pkg::TASK_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rrqs_pkg::req_item_type item,
   output rrqs_pkg::rsp_item_type result
);
   import rrqs_pkg::*;

   // tasks above what task_req can address never leave the blocked state
   localparam int TASK_SLOTS = (TASK_COUNT < TASK_ADDR_MAX) ? TASK_COUNT : TASK_ADDR_MAX;
   localparam int SLOT_W     = $clog2(TASK_SLOTS);
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
   localparam int SUM_W      = SLOT_W + 1;

   status_type        status_ff   [TASK_SLOTS];
   status_type        status_in   [TASK_SLOTS];
   logic [QNT_W-1:0]  quantum_ff  [TASK_SLOTS];
   logic [QNT_W-1:0]  quantum_in  [TASK_SLOTS];
   logic [SLOT_W-1:0] fifo_ff     [TASK_SLOTS];
   logic [SLOT_W-1:0] fifo_in     [TASK_SLOTS];
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] current_ff, current_in;
   logic [QNT_W-1:0]  ticks_ff, ticks_in;
   // copy of quantum_table[current], so the table has one read address
   logic [QNT_W-1:0]  cur_quantum_ff, cur_quantum_in;

   logic              nonempty;
   logic [SLOT_W-1:0] head_task;
   logic [SLOT_W-1:0] next_task;
   logic [QNT_W-1:0]  next_quantum;
   logic [SLOT_W-1:0] head_inc;
   logic [SUM_W-1:0]  tail_sum;
   logic [SUM_W-1:0]  tail_wrap;
   logic [SLOT_W-1:0] tail;
   logic [SLOT_W-1:0] req_slot;
   logic              req_ok;
   logic [QNT_W-1:0]  ticks_dec;
   logic              refused;

   always_comb begin
      nonempty     = (count_ff != '0);
      head_task    = fifo_ff[head_ff];
      next_task    = nonempty ? head_task : '0;
      next_quantum = quantum_ff[next_task];
      head_inc     = (head_ff == SLOT_W'(TASK_SLOTS - 1)) ? '0 : head_ff + 1'b1;
      tail_sum     = SUM_W'(head_ff) + SUM_W'(count_ff);
      tail_wrap    = (tail_sum >= SUM_W'(TASK_SLOTS)) ? tail_sum - SUM_W'(TASK_SLOTS)
                                                      : tail_sum;
      tail         = tail_wrap[SLOT_W-1:0];
      req_slot     = item.task_req[SLOT_W-1:0];
      req_ok       = (32'(item.task_req) < TASK_COUNT);
      ticks_dec    = (ticks_ff == '0) ? '0 : ticks_ff - 1'b1;
   end

   always_comb begin
      status_in      = status_ff;
      quantum_in     = quantum_ff;
      fifo_in        = fifo_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      current_in     = current_ff;
      ticks_in       = ticks_ff;
      cur_quantum_in = cur_quantum_ff;
      refused        = 1'b0;

      case (item.command)
         CMD_TICK: begin
            if (ticks_dec != '0) begin
               ticks_in = ticks_dec;
            end else if (nonempty) begin
               // expiry with work waiting: rotate
               head_in = head_inc;
               if (current_ff != '0) begin
                  fifo_in[tail]         = current_ff;
                  status_in[current_ff] = TS_READY;
               end else begin
                  status_in[0] = TS_BLOCKED;
                  count_in     = count_ff - 1'b1;
               end
               status_in[head_task] = TS_RUNNING;
               current_in           = head_task;
               ticks_in             = next_quantum;
               cur_quantum_in       = next_quantum;
            end else begin
               ticks_in = cur_quantum_ff;
            end
         end
         CMD_MAKE_READY: begin
            if (!req_ok || item.task_req == '0 || status_ff[req_slot] != TS_BLOCKED) begin
               refused = 1'b1;
            end else begin
               fifo_in[tail]       = req_slot;
               count_in            = count_ff + 1'b1;
               status_in[req_slot] = TS_READY;
            end
         end
         CMD_BLOCK: begin
            if (current_ff == '0) begin
               refused = 1'b1;
            end else begin
               status_in[current_ff] = TS_BLOCKED;
               if (nonempty) begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
               status_in[next_task] = TS_RUNNING;
               current_in           = next_task;
               ticks_in             = next_quantum;
               cur_quantum_in       = next_quantum;
            end
         end
         CMD_SET_QUANTUM: begin
            if (!req_ok || item.quantum_value == '0) begin
               refused = 1'b1;
            end else begin
               quantum_in[req_slot] = item.quantum_value;
               if (req_slot == current_ff) begin
                  cur_quantum_in = item.quantum_value;
               end
            end
         end
         default: begin
            refused = 1'b1;
         end
      endcase

      result.running_task = TASK_W'(current_in);
      result.switched     = (current_in != current_ff);
      result.refused      = refused;
      result.remaining    = ticks_in;
      result.ready_count  = CNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            status_ff[i]  <= TS_BLOCKED;
            quantum_ff[i] <= QUANTUM_RESET;
         end
         status_ff[0]   <= TS_RUNNING;
         head_ff        <= '0;
         count_ff       <= '0;
         current_ff     <= '0;
         ticks_ff       <= QUANTUM_RESET;
         cur_quantum_ff <= QUANTUM_RESET;
      end else if (fire) begin
         status_ff      <= status_in;
         quantum_ff     <= quantum_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         current_ff     <= current_in;
         ticks_ff       <= ticks_in;
         cur_quantum_ff <= cur_quantum_in;
      end
   end

   // FIFO entries are only read once counted
   always_ff @(posedge clock) begin
      if (fire) begin
         fifo_ff <= fifo_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TASK_SLOTS - 1))
      else $error("ready count exceeds non-idle task count");

   a_current_running: assert property (@(posedge clock) disable iff (reset)
      status_ff[current_ff] == TS_RUNNING)
      else $error("running task not marked running");

   a_idle_not_queued: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> fifo_ff[head_ff] != '0)
      else $error("idle task at FIFO head");

   a_quantum_copy: assert property (@(posedge clock) disable iff (reset)
      cur_quantum_ff == quantum_ff[current_ff])
      else $error("running quantum copy out of sync with table");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      fire && refused |=> $stable(current_ff) && $stable(count_ff) && $stable(ticks_ff)
                          && $stable(head_ff))
      else $error("refused command changed state");

endmodule

@@ rtl/round_robin_quantum_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Round-robin time-slice scheduler with an idle task; one result per command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | command, task_req, quantum_value
//  rsp     | out       | rsp_valid/rsp_stall | running_task, switched, refused,
//          |           |                     | remaining, ready_count
//
//  One command per cycle sustained while rsp_stall is low; each command goes
//  through the input register, then the state update and result register in
//  the same pass. Reset is synchronous.
//  While rsp_stall is high the result beat holds and one more command is
//  held in the input register, after which req_stall rises.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler #(
   parameter int TASK_COUNT = rrqs_pkg::TASK_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rrqs_pkg::CMD_W-1:0]     req_command,
   input  logic [rrqs_pkg::TASK_W-1:0]    req_task_req,
   input  logic [rrqs_pkg::QNT_W-1:0]     req_quantum_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rrqs_pkg::TASK_W-1:0]    rsp_running_task,
   output logic                           rsp_switched,
   output logic                           rsp_refused,
   output logic [rrqs_pkg::QNT_W-1:0]     rsp_remaining,
   output logic [rrqs_pkg::CNT_OUT_W-1:0] rsp_ready_count
);
   import rrqs_pkg::*;

   req_item_type req_ff, req_in;
   logic         req_valid_ff, req_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type core_rsp;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         fire;
   logic         req_take;

   always_comb begin
      advance   = !rsp_valid_ff || !rsp_stall;
      fire      = req_valid_ff && advance;
      req_stall = req_valid_ff && !advance;
      req_take  = req_valid && !req_stall;

      req_in.command       = cmd_type'(req_command);
      req_in.task_req      = req_task_req;
      req_in.quantum_value = req_quantum_value;

      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      rsp_valid_in = advance ? fire : rsp_valid_ff;
   end

   rrqs_core #(
      .TASK_COUNT (TASK_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_ff),
      .result (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_task = rsp_ff.running_task;
   assign rsp_switched     = rsp_ff.switched;
   assign rsp_refused      = rsp_ff.refused;
   assign rsp_remaining    = rsp_ff.remaining;
   assign rsp_ready_count  = rsp_ff.ready_count;

endmodule

@@ sim/tb_round_robin_quantum_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_quantum_scheduler
// Drives scheduler commands through the req channel and checks every rsp beat
// against an in-order scheduling predictor kept inside the bench. Directed
// commands cover refusals, expiry and preemption of the idle task; random
// traffic follows in three idling profiles, with a long rsp hold-off.
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler;
   import rrqs_pkg::*;

   localparam int NUM_TASKS   = TASK_COUNT_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_command = '0;
   logic [TASK_W-1:0]    req_task_req = '0;
   logic [QNT_W-1:0]     req_quantum_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [TASK_W-1:0]    rsp_running_task;
   logic                 rsp_switched;
   logic                 rsp_refused;
   logic [QNT_W-1:0]     rsp_remaining;
   logic [CNT_OUT_W-1:0] rsp_ready_count;

   round_robin_quantum_scheduler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_task_req      (req_task_req),
      .req_quantum_value (req_quantum_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_running_task  (rsp_running_task),
      .rsp_switched      (rsp_switched),
      .rsp_refused       (rsp_refused),
      .rsp_remaining     (rsp_remaining),
      .rsp_ready_count   (rsp_ready_count)
   );

   // scheduler state as the predictor sees it
   status_type       task_state  [NUM_TASKS];
   logic [QNT_W-1:0] slice_table [NUM_TASKS];
   logic [TASK_W-1:0] ready_ring [NUM_TASKS];
   int               ring_head;
   int               ring_count;
   logic [TASK_W-1:0] cur_task;
   logic [QNT_W-1:0] ticks;

   req_item_type command_backlog[$];
   rsp_item_type predicted_outcomes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int fail_count = 0;
   int cycle_count = 0;

   function automatic logic [TASK_W-1:0] ring_pop();
      logic [TASK_W-1:0] t;
      t = ready_ring[ring_head];
      ring_head = (ring_head + 1) % NUM_TASKS;
      ring_count--;
      return t;
   endfunction

   function automatic void ring_push(logic [TASK_W-1:0] t);
      if (ring_count >= NUM_TASKS) return;
      ready_ring[(ring_head + ring_count) % NUM_TASKS] = t;
      ring_count++;
      task_state[t] = TS_READY;
   endfunction

   function automatic rsp_item_type apply_command(req_item_type c);
      logic [TASK_W-1:0] prior_task;
      logic [TASK_W-1:0] nxt;
      logic              deny;
      rsp_item_type      r;
      prior_task = cur_task;
      deny = 1'b0;
      case (c.command)
         CMD_TICK: begin
            if (ticks != 0) ticks = ticks - 1'b1;
            if (ticks == 0) begin
               if (ring_count > 0) begin
                  nxt = ring_pop();
                  // the idle task is never queued, it just drops to blocked
                  if (cur_task != 0) ring_push(cur_task);
                  else task_state[0] = TS_BLOCKED;
                  task_state[nxt] = TS_RUNNING;
                  cur_task = nxt;
                  ticks = slice_table[nxt];
               end else begin
                  ticks = slice_table[cur_task];
               end
            end
         end
         CMD_MAKE_READY: begin
            if (int'(c.task_req) >= NUM_TASKS || c.task_req == 0 ||
                task_state[c.task_req] != TS_BLOCKED)
               deny = 1'b1;
            else
               ring_push(c.task_req);
         end
         CMD_BLOCK: begin
            if (cur_task == 0) begin
               deny = 1'b1;
            end else begin
               task_state[cur_task] = TS_BLOCKED;
               nxt = (ring_count > 0) ? ring_pop() : '0;
               task_state[nxt] = TS_RUNNING;
               cur_task = nxt;
               ticks = slice_table[nxt];
            end
         end
         default: begin
            // running task keeps its current count; new value on next reload
            if (int'(c.task_req) >= NUM_TASKS || c.quantum_value == 0)
               deny = 1'b1;
            else
               slice_table[c.task_req] = c.quantum_value;
         end
      endcase
      r.running_task = cur_task;
      r.switched     = (cur_task != prior_task);
      r.refused      = deny;
      r.remaining    = ticks;
      r.ready_count  = CNT_OUT_W'(ring_count);
      return r;
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // driver: one beat offered at a time, held while stalled
   always @(posedge clock) begin
      req_item_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            c.command       = cmd_type'(req_command);
            c.task_req      = req_task_req;
            c.quantum_value = req_quantum_value;
            predicted_outcomes.push_back(apply_command(c));
         end
         if (!req_valid || !req_stall) begin
            if (command_backlog.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               c = command_backlog.pop_front();
               req_valid         <= 1'b1;
               req_command       <= c.command;
               req_task_req      <= c.task_req;
               req_quantum_value <= c.quantum_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outcomes.size() == 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
               $display("unexpected rsp beat: task %0d sw %0b ref %0b rem %0d cnt %0d",
                        rsp_running_task, rsp_switched, rsp_refused,
                        rsp_remaining, rsp_ready_count);
         end else begin
            e = predicted_outcomes.pop_front();
            if (e.running_task != rsp_running_task || e.switched != rsp_switched ||
                e.refused != rsp_refused || e.remaining != rsp_remaining ||
                e.ready_count != rsp_ready_count) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) begin
                  $write("mismatch: exp task %0d sw %0b ref %0b rem %0d cnt %0d",
                         e.running_task, e.switched, e.refused, e.remaining,
                         e.ready_count);
                  $display(" / got task %0d sw %0b ref %0b rem %0d cnt %0d",
                           rsp_running_task, rsp_switched, rsp_refused,
                           rsp_remaining, rsp_ready_count);
               end
            end
         end
      end
   end

   // rsp_stall generator
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         // long hold-off: the sender keeps offering until req_stall rises
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic queue_cmd(cmd_type op, int tsk, int qv);
      req_item_type c;
      c.command       = op;
      c.task_req      = TASK_W'(tsk);
      c.quantum_value = QNT_W'(qv);
      command_backlog.push_back(c);
   endtask

   task automatic queue_random(int n);
      req_item_type c;
      int roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 45)      c.command = CMD_TICK;
         else if (roll < 70) c.command = CMD_MAKE_READY;
         else if (roll < 85) c.command = CMD_BLOCK;
         else                c.command = CMD_SET_QUANTUM;
         c.task_req = TASK_W'($urandom_range(NUM_TASKS - 1));
         // short slices keep expiry and rotation frequent
         roll = $urandom_range(99);
         if (roll < 60)      c.quantum_value = QNT_W'($urandom_range(4, 1));
         else if (roll < 70) c.quantum_value = '0;
         else if (roll < 85) c.quantum_value = QNT_W'($urandom_range(30, 5));
         else                c.quantum_value = QNT_W'($urandom_range(16'hFFFF));
         command_backlog.push_back(c);
      end
   endtask

   task automatic wait_drained();
      while (command_backlog.size() != 0 || req_valid ||
             predicted_outcomes.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < NUM_TASKS; i++) begin
         task_state[i]  = TS_BLOCKED;
         slice_table[i] = QUANTUM_RESET;
         ready_ring[i]  = '0;
      end
      task_state[0] = TS_RUNNING;
      ring_head  = 0;
      ring_count = 0;
      cur_task   = '0;
      ticks      = QUANTUM_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: refusals, extremes, idle preemption at expiry
      queue_cmd(CMD_BLOCK, 0, 0);              // block while idle runs
      queue_cmd(CMD_MAKE_READY, 0, 0);         // idle task never queued
      queue_cmd(CMD_SET_QUANTUM, 5, 0);        // zero quantum refused
      queue_cmd(CMD_SET_QUANTUM, 0, 1);        // running task: table only
      queue_cmd(CMD_SET_QUANTUM, 1, 1);
      queue_cmd(CMD_SET_QUANTUM, 15, 16'hFFFF);
      queue_cmd(CMD_MAKE_READY, 1, 16'hFFFF);
      queue_cmd(CMD_MAKE_READY, 1, 0);         // already ready
      queue_cmd(CMD_MAKE_READY, 15, 0);
      for (int i = 0; i < 20; i++)
         queue_cmd(CMD_TICK, 0, 0);            // last one preempts idle
      queue_cmd(CMD_TICK, 10, 16'h5A5A);       // task 1 rotates to the tail
      queue_cmd(CMD_MAKE_READY, 15, 0);        // running task refused
      queue_cmd(CMD_SET_QUANTUM, 15, 3);
      queue_cmd(CMD_BLOCK, 0, 0);
      queue_cmd(CMD_BLOCK, 0, 0);              // empty queue: idle returns
      queue_cmd(CMD_TICK, 0, 0);               // idle reload, nothing ready
      queue_cmd(CMD_MAKE_READY, 2, 0);
      queue_cmd(CMD_TICK, 0, 0);
      wait_drained();

      send_idle_pct = 31;
      recv_idle_pct = 79;
      queue_random(530);
      wait_drained();

      send_idle_pct = 79;
      recv_idle_pct = 31;
      queue_random(530);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed = 1'b1;
      queue_random(540);
      wait_drained();

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
